// File: design/gkwi_pkg.sv
// ----------------------------------------------------------------------------
// gkwi_pkg
// shared widths, register indexes, defaults and control structs of the
// global k-winner inhibition block
// ----------------------------------------------------------------------------
package gkwi_pkg;

   // fixed field widths
   localparam int SCORE_W      = 24;
   localparam int COL_W        = 11;
   localparam int K_W          = 7;
   localparam int THR_W        = 24;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 40;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // parameter defaults
   localparam int NUM_COLUMNS_DEF = 2048;
   localparam int MAX_WINNERS_DEF = 64;
   localparam int SCORE_BITS_DEF  = 24;

   // register reset values
   localparam logic [K_W-1:0]   NUM_WINNERS_RST = 7'd40;
   localparam logic [THR_W-1:0] THRESHOLD_RST   = 24'd0;

   // register indexes, taken from paddr[2]
   localparam logic REG_NUM_WINNERS = 1'b0;
   localparam logic REG_THRESHOLD   = 1'b1;

   typedef struct packed {
      logic insert;
      logic load_k;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic word_end;
   } sts_type;

endpackage

// File: design/global_k_winner_inhibition.sv
// a column enters the ranked list in the cycle after it is accepted
// loading: one column per cycle; after the last column the winners leave
//    one per cycle from the head of the cell row while the receiver
//    takes them
// reset: clears run state, counters and output valid, and loads register
//    defaults; the cell contents are not cleared
// ----------------------------------------------------------------------------
// global_k_winner_inhibition
// top-k column selection over a stream of scores with stimulus threshold
// ----------------------------------------------------------------------------
module global_k_winner_inhibition #(
   parameter int NUM_COLUMNS = gkwi_pkg::NUM_COLUMNS_DEF,
   parameter int MAX_WINNERS = gkwi_pkg::MAX_WINNERS_DEF,
   parameter int SCORE_BITS  = gkwi_pkg::SCORE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gkwi_pkg::REQ_DATA_W-1:0]   req_tdata,   // score[23:0]
   input  logic                              req_tlast,   // is_last_column
   // result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gkwi_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // winner_column[10:0], winner_score[34:11], zero[39:35]
   output logic                              rsp_tuser,   // no_winner
   output logic                              rsp_tlast,   // end_of_run
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gkwi_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gkwi_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gkwi_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   gkwi_pkg::cmd_type             cmd;
   gkwi_pkg::sts_type             sts;
   logic [gkwi_pkg::K_W-1:0]      num_winners;
   logic [gkwi_pkg::THR_W-1:0]    threshold;

   gkwi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .num_winners (num_winners),
      .threshold   (threshold)
   );

   gkwi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gkwi_datapath #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .MAX_WINNERS (MAX_WINNERS),
      .SCORE_BITS  (SCORE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .in_score    (req_tdata),
      .num_winners (num_winners),
      .threshold   (threshold),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// File: design/gkwi_csr.sv
// ----------------------------------------------------------------------------
// gkwi_csr
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module gkwi_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gkwi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gkwi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gkwi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [gkwi_pkg::K_W-1:0]           num_winners,
   output logic [gkwi_pkg::THR_W-1:0]         threshold
);

   logic [gkwi_pkg::K_W-1:0]   nw_ff, nw_in;
   logic [gkwi_pkg::THR_W-1:0] thr_ff, thr_in;
   logic                       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      nw_in  = nw_ff;
      thr_in = thr_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            gkwi_pkg::REG_NUM_WINNERS: nw_in  = csr_pwdata[gkwi_pkg::K_W-1:0];
            gkwi_pkg::REG_THRESHOLD:   thr_in = csr_pwdata[gkwi_pkg::THR_W-1:0];
            default:                   nw_in  = nw_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         gkwi_pkg::REG_NUM_WINNERS:
            csr_prdata = {{(gkwi_pkg::CSR_DATA_W-gkwi_pkg::K_W){1'b0}}, nw_ff};
         gkwi_pkg::REG_THRESHOLD:
            csr_prdata = {{(gkwi_pkg::CSR_DATA_W-gkwi_pkg::THR_W){1'b0}}, thr_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nw_ff  <= gkwi_pkg::NUM_WINNERS_RST;
         thr_ff <= gkwi_pkg::THRESHOLD_RST;
      end else begin
         nw_ff  <= nw_in;
         thr_ff <= thr_in;
      end
   end

   assign num_winners = nw_ff;
   assign threshold   = thr_ff;

endmodule

// File: design/gkwi_ctrl.sv
// ----------------------------------------------------------------------------
// gkwi_ctrl
// run controller: load columns into the ranked list, then emit winners
// ----------------------------------------------------------------------------
module gkwi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tlast,
   output logic              req_tready,
   input  gkwi_pkg::sts_type sts,
   output gkwi_pkg::cmd_type cmd
);

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;

   assign req_tready = (state_ff == ST_LOAD);

   always_comb begin
      cmd.insert = 1'b0;
      cmd.load_k = 1'b0;
      cmd.pop    = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.insert = req_tvalid;
            cmd.load_k = req_tvalid && req_tlast;
            if (cmd.load_k) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.pop = sts.out_free;
            if (cmd.pop && sts.word_end) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // a run ends only after its final word has left the list
   a_end_returns: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && sts.word_end) |=> (state_ff == ST_LOAD))
      else $error("controller did not return to load after final word");

   // the last column always starts an emission
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.load_k |=> (!req_tready && state_ff == ST_EMIT))
      else $error("last column did not start emission");

endmodule

// File: design/gkwi_datapath.sv
// ----------------------------------------------------------------------------
// gkwi_datapath
// systolic insertion list of ranked cells, column counter, winner count
// and result output register
// ----------------------------------------------------------------------------
module gkwi_datapath #(
   parameter int NUM_COLUMNS = gkwi_pkg::NUM_COLUMNS_DEF,
   parameter int MAX_WINNERS = gkwi_pkg::MAX_WINNERS_DEF,
   parameter int SCORE_BITS  = gkwi_pkg::SCORE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gkwi_pkg::cmd_type                 cmd,
   output gkwi_pkg::sts_type                 sts,
   input  logic [gkwi_pkg::SCORE_W-1:0]      in_score,
   input  logic [gkwi_pkg::K_W-1:0]          num_winners,
   input  logic [gkwi_pkg::THR_W-1:0]        threshold,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gkwi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_WINNERS + 1);
   localparam int CC_W  = $clog2(NUM_COLUMNS + 1);
   localparam int CMP_W = SCORE_BITS + gkwi_pkg::THR_W;

   logic [SCORE_BITS-1:0]        score_ff [MAX_WINNERS];
   logic [SCORE_BITS-1:0]        score_in [MAX_WINNERS];
   logic [gkwi_pkg::COL_W-1:0]   col_ff   [MAX_WINNERS];
   logic [gkwi_pkg::COL_W-1:0]   col_in   [MAX_WINNERS];
   logic [SCORE_BITS-1:0]        up_score [MAX_WINNERS];
   logic [gkwi_pkg::COL_W-1:0]   up_col   [MAX_WINNERS];
   logic [SCORE_BITS-1:0]        dn_score [MAX_WINNERS];
   logic [gkwi_pkg::COL_W-1:0]   dn_col   [MAX_WINNERS];
   logic [MAX_WINNERS-1:0]       gt;
   logic [MAX_WINNERS-1:0]       prev_gt;

   logic [CNT_W-1:0]             count_ff, count_in, count_after;
   logic [CNT_W-1:0]             rem_ff, rem_in, rem_load;
   logic [CC_W-1:0]              colcnt_ff, colcnt_in;

   logic [SCORE_BITS+gkwi_pkg::SCORE_W-1:0] score_ext;
   logic [CC_W+gkwi_pkg::COL_W-1:0]         col_ext;
   logic [SCORE_BITS-1:0]                   new_score;
   logic [gkwi_pkg::COL_W-1:0]              new_col;
   logic [CMP_W-1:0]                        thr_cmp, head_cmp, next_cmp;
   logic [CMP_W-1:0]                        head_ext;
   logic [gkwi_pkg::K_W-1:0]                k_clamp;

   logic col_full, ins_en, grow, clear, head_ok, next_ok, word_end;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gkwi_pkg::COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [gkwi_pkg::SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic                         rsp_nw_ff, rsp_nw_in;
   logic                         rsp_end_ff, rsp_end_in;

   // incoming column
   assign score_ext = {{SCORE_BITS{1'b0}}, in_score};
   assign new_score = score_ext[SCORE_BITS-1:0];
   assign col_ext   = {{gkwi_pkg::COL_W{1'b0}}, colcnt_ff};
   assign new_col   = col_ext[gkwi_pkg::COL_W-1:0];
   assign col_full  = (colcnt_ff == CC_W'(NUM_COLUMNS));
   assign ins_en    = cmd.insert && !col_full;
   assign grow      = ins_en && (count_ff != CNT_W'(MAX_WINNERS));

   // cell row
   for (genvar i = 0; i < MAX_WINNERS; i++) begin : g_cell
      assign gt[i] = (CNT_W'(i) < count_ff) && (score_ff[i] > new_score);
      if (i == 0) begin : g_head
         assign prev_gt[i]  = 1'b1;
         assign up_score[i] = new_score;
         assign up_col[i]   = new_col;
      end else begin : g_body
         assign prev_gt[i]  = gt[i-1];
         assign up_score[i] = score_ff[i-1];
         assign up_col[i]   = col_ff[i-1];
      end
      if (i == MAX_WINNERS - 1) begin : g_tail
         assign dn_score[i] = score_ff[i];
         assign dn_col[i]   = col_ff[i];
      end else begin : g_mid
         assign dn_score[i] = score_ff[i+1];
         assign dn_col[i]   = col_ff[i+1];
      end

      always_comb begin
         score_in[i] = score_ff[i];
         col_in[i]   = col_ff[i];
         if (ins_en && !gt[i]) begin
            if (prev_gt[i]) begin
               score_in[i] = new_score;
               col_in[i]   = new_col;
            end else begin
               score_in[i] = up_score[i];
               col_in[i]   = up_col[i];
            end
         end else if (cmd.pop) begin
            score_in[i] = dn_score[i];
            col_in[i]   = dn_col[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_WINNERS; i++) begin
         score_ff[i] <= score_in[i];
         col_ff[i]   <= col_in[i];
      end
   end

   // winner count for this run
   assign count_after = grow ? count_ff + 1'b1 : count_ff;

   always_comb begin
      if (num_winners == '0) begin
         k_clamp = 7'd1;
      end else if (num_winners > gkwi_pkg::K_W'(MAX_WINNERS)) begin
         k_clamp = gkwi_pkg::K_W'(MAX_WINNERS);
      end else begin
         k_clamp = num_winners;
      end
   end

   assign rem_load = (k_clamp < gkwi_pkg::K_W'(count_after)) ? CNT_W'(k_clamp) : count_after;

   // emission of the list head
   assign thr_cmp  = {{SCORE_BITS{1'b0}}, threshold};
   assign head_ext = {{gkwi_pkg::THR_W{1'b0}}, score_ff[0]};
   assign head_cmp = head_ext;
   assign head_ok  = (rem_ff != '0) && (head_cmp >= thr_cmp);

   if (MAX_WINNERS > 1) begin : g_next
      assign next_cmp = {{gkwi_pkg::THR_W{1'b0}}, score_ff[1]};
      assign next_ok  = (rem_ff > CNT_W'(1)) && (next_cmp >= thr_cmp);
   end else begin : g_single
      assign next_cmp = '0;
      assign next_ok  = 1'b0;
   end

   assign word_end = !head_ok || !next_ok;
   assign clear    = cmd.pop && word_end;

   always_comb begin
      count_in  = count_ff;
      colcnt_in = colcnt_ff;
      rem_in    = rem_ff;
      if (clear) begin
         count_in  = '0;
         colcnt_in = '0;
         rem_in    = '0;
      end else begin
         count_in = count_after;
         if (ins_en) begin
            colcnt_in = colcnt_ff + 1'b1;
         end
         if (cmd.load_k) begin
            rem_in = rem_load;
         end else if (cmd.pop && rem_ff != '0) begin
            rem_in = rem_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         colcnt_ff <= '0;
         rem_ff    <= '0;
      end else begin
         count_ff  <= count_in;
         colcnt_ff <= colcnt_in;
         rem_ff    <= rem_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_col_in   = rsp_col_ff;
      rsp_score_in = rsp_score_ff;
      rsp_nw_in    = rsp_nw_ff;
      rsp_end_in   = rsp_end_ff;
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
         rsp_end_in   = word_end;
         if (head_ok) begin
            rsp_col_in   = col_ff[0];
            rsp_score_in = head_ext[gkwi_pkg::SCORE_W-1:0];
            rsp_nw_in    = 1'b0;
         end else begin
            rsp_col_in   = '0;
            rsp_score_in = '0;
            rsp_nw_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_col_ff   <= rsp_col_in;
      rsp_score_ff <= rsp_score_in;
      rsp_nw_ff    <= rsp_nw_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(gkwi_pkg::RSP_DATA_W-gkwi_pkg::SCORE_W-gkwi_pkg::COL_W){1'b0}},
                        rsp_score_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_nw_ff;
   assign rsp_tlast  = rsp_end_ff;

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign sts.word_end = word_end;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_WINNERS))
      else $error("ranked count above list depth");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= count_ff)
      else $error("winners left to emit exceed ranked entries");

   if (MAX_WINNERS > 1) begin : g_order_chk
      a_head_order: assert property (@(posedge clock) disable iff (reset)
         (rem_ff == '0 && count_ff >= CNT_W'(2)) |-> (score_ff[0] >= score_ff[1]))
         else $error("ranked list out of order at head");
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for global_k_winner_inhibition: streams column scores
// with random gaps and stalls on both sides, keeps its own ranked insertion
// list to predict the winner words of each run, and compares every result
// word field by field; registers are changed between runs and read back
// ----------------------------------------------------------------------------
module tb;

   localparam int NUM_COLUMNS  = gkwi_pkg::NUM_COLUMNS_DEF;
   localparam int MAX_WINNERS  = gkwi_pkg::MAX_WINNERS_DEF;
   localparam int RANDOM_ITEMS = 353;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 4;
   localparam int WATCHDOG     = 2000;
   localparam logic [gkwi_pkg::CSR_ADDR_W-1:0] CSR_K   = {gkwi_pkg::REG_NUM_WINNERS, 2'b00};
   localparam logic [gkwi_pkg::CSR_ADDR_W-1:0] CSR_THR = {gkwi_pkg::REG_THRESHOLD, 2'b00};

   typedef struct packed {
      logic [gkwi_pkg::COL_W-1:0]   col;
      logic [gkwi_pkg::SCORE_W-1:0] score;
      logic                         no_win;
      logic                         eor;
   } winner_word_type;

   typedef struct packed {
      logic                            reg_write;
      logic [gkwi_pkg::CSR_ADDR_W-1:0] addr;
      logic [gkwi_pkg::CSR_DATA_W-1:0] value;
      logic [gkwi_pkg::SCORE_W-1:0]    score;
      logic                            last_col;
      logic                            typed;
      winner_word_type                 word;
   } stim_row_type;

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [gkwi_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                            req_tlast   = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [gkwi_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [gkwi_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [gkwi_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [gkwi_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // predictor state
   logic [gkwi_pkg::SCORE_W-1:0] ranked_score [MAX_WINNERS];
   logic [gkwi_pkg::COL_W-1:0]   ranked_col   [MAX_WINNERS];
   int                           ranked_len   = 0;
   int                           column_count = 0;
   logic [gkwi_pkg::K_W-1:0]     k_cfg        = gkwi_pkg::NUM_WINNERS_RST;
   logic [gkwi_pkg::THR_W-1:0]   thr_cfg      = gkwi_pkg::THRESHOLD_RST;

   winner_word_type winners_due [$];
   int              mismatches  = 0;
   int              idle_cycles = 0;
   int              random_items = 0;
   bit              req_burst   = 0;
   bit              rsp_burst   = 0;
   bit              hold_req    = 0;

   stim_row_type directed_plan [24] = '{
      '{1'b0, CSR_K,   32'd0,         24'hFFFFFF, 1'b1, 1'b1,
        '{11'd0, 24'hFFFFFF, 1'b0, 1'b1}},
      '{1'b0, CSR_K,   32'd0,         24'h000000, 1'b1, 1'b1,
        '{11'd0, 24'h000000, 1'b0, 1'b1}},
      '{1'b1, CSR_THR, 32'h00000100,  24'h000000, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h0000FF, 1'b1, 1'b1,
        '{11'd0, 24'h000000, 1'b1, 1'b1}},
      '{1'b0, CSR_K,   32'd0,         24'h000100, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000100, 1'b1, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h0000FF, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000200, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000180, 1'b1, 1'b0, '0},
      '{1'b1, CSR_K,   32'd0,         24'h000000, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000300, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000300, 1'b1, 1'b0, '0},
      '{1'b1, CSR_K,   32'd127,       24'h000000, 1'b0, 1'b0, '0},
      '{1'b1, CSR_THR, 32'h00FFFFFF,  24'h000000, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'hFFFFFF, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'hFFFFFE, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'hFFFFFF, 1'b1, 1'b0, '0},
      '{1'b1, CSR_K,   32'd2,         24'h000000, 1'b0, 1'b0, '0},
      '{1'b1, CSR_THR, 32'd0,         24'h000000, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000005, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000009, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000007, 1'b0, 1'b0, '0},
      '{1'b0, CSR_K,   32'd0,         24'h000009, 1'b1, 1'b0, '0},
      '{1'b1, CSR_K,   32'd40,        24'h000000, 1'b0, 1'b0, '0}
   };

   global_k_winner_inhibition u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // score[23:0]
      .req_tlast   (req_tlast),    // is_last_column
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // winner_column[10:0], winner_score[34:11], zero[39:35]
      .rsp_tuser   (rsp_tuser),    // no_winner
      .rsp_tlast   (rsp_tlast),    // end_of_run
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ranked insertion list; returns the winner words when the column closes a run
   function automatic void rank_column(input logic [gkwi_pkg::SCORE_W-1:0] score,
                                       input logic last_col,
                                       output winner_word_type won [$]);
      int pos;
      int i;
      int k;
      int n;
      winner_word_type w;
      won = {};
      if (column_count < NUM_COLUMNS) begin
         pos = 0;
         while (pos < ranked_len && ranked_score[pos] > score) pos++;
         if (pos < MAX_WINNERS) begin
            for (i = (ranked_len < MAX_WINNERS) ? ranked_len : MAX_WINNERS - 1;
                 i > pos; i--) begin
               ranked_score[i] = ranked_score[i-1];
               ranked_col[i]   = ranked_col[i-1];
            end
            ranked_score[pos] = score;
            ranked_col[pos]   = column_count[gkwi_pkg::COL_W-1:0];
            if (ranked_len < MAX_WINNERS) ranked_len++;
         end
         column_count++;
      end
      if (last_col) begin
         k = k_cfg;
         if (k == 0) k = 1;
         if (k > MAX_WINNERS) k = MAX_WINNERS;
         if (k > ranked_len) k = ranked_len;
         n = 0;
         while (n < k && ranked_score[n] >= thr_cfg) n++;
         if (n == 0) begin
            w = '{'0, '0, 1'b1, 1'b1};
            won = {won, w};
         end else begin
            for (i = 0; i < n; i++) begin
               w = '{ranked_col[i], ranked_score[i], 1'b0, i == n - 1};
               won = {won, w};
            end
         end
         ranked_len   = 0;
         column_count = 0;
      end
   endfunction

   task automatic send_column(input logic [gkwi_pkg::SCORE_W-1:0] score,
                              input logic last_col,
                              input logic typed, input winner_word_type typed_word);
      int gap;
      winner_word_type won [$];
      if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : int'($urandom_range(0, 3));
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= score;
      req_tlast  <= last_col;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rank_column(score, last_col, won);
      if (typed) winners_due = {winners_due, typed_word};
      else winners_due = {winners_due, won};
   endtask

   task automatic send_run(input int len);
      logic [gkwi_pkg::SCORE_W-1:0] score;
      int i;
      int n;
      n = (len < RANDOM_ITEMS - random_items) ? len : RANDOM_ITEMS - random_items;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: score = gkwi_pkg::SCORE_W'($urandom_range(0, 7));
            1: score = gkwi_pkg::SCORE_W'(thr_cfg + $urandom_range(0, 2) - 1);
            2: score = 24'hFFFFFF;
            3: score = 24'h000000;
            4: score = {3'($urandom_range(0, 7)), 21'h0};
            default: score = gkwi_pkg::SCORE_W'($urandom);
         endcase
         send_column(score, i == n - 1, 1'b0, '0);
         random_items++;
      end
   endtask

   // waits for the block to drain, writes a register, then reads it back
   task automatic write_register(input logic [gkwi_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [gkwi_pkg::CSR_DATA_W-1:0] value);
      logic [gkwi_pkg::CSR_DATA_W-1:0] mask;
      mask = (addr == CSR_K) ? 32'h7F : 32'hFFFFFF;
      req_tvalid <= 1'b0;
      while (winners_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == CSR_K) k_cfg = value[gkwi_pkg::K_W-1:0];
      else thr_cfg = value[gkwi_pkg::THR_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if ((csr_prdata & mask) !== (value & mask)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register readback at %h: expected %h got %h",
                     addr, value & mask, csr_prdata & mask);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side
   initial begin : rsp_side
      int gap;
      winner_word_type got;
      winner_word_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
            gap = rsp_burst ? 0 : int'($urandom_range(0, 3));
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid && !hold_req) @(posedge clock);
         if (rsp_tvalid) begin
            got = '{rsp_tdata[gkwi_pkg::COL_W-1:0],
                    rsp_tdata[gkwi_pkg::COL_W +: gkwi_pkg::SCORE_W], rsp_tuser, rsp_tlast};
            if (winners_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: col %0d score %h no_winner %b end %b",
                           got.col, got.score, got.no_win, got.eor);
            end else begin
               want = winners_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"word mismatch: expected col %0d score %h no_winner %b end %b,",
                               " got col %0d score %h no_winner %b end %b"},
                              want.col, want.score, want.no_win, want.eor,
                              got.col, got.score, got.no_win, got.eor);
               end
            end
         end
      end
   end

   // ends the run when nothing moves for too long
   initial begin : watchdog
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : req_side
      int phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[r]) begin
         if (directed_plan[r].reg_write)
            write_register(directed_plan[r].addr, directed_plan[r].value);
         else
            send_column(directed_plan[r].score, directed_plan[r].last_col,
                        directed_plan[r].typed, directed_plan[r].word);
      end

      for (phase = 0; random_items < RANDOM_ITEMS; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_K, 32'd64);
               write_register(CSR_THR, 32'd0);
            end
            1: begin
               write_register(CSR_K, 32'd1);
               write_register(CSR_THR, 32'hFFFFFF);
            end
            2: begin
               write_register(CSR_K, 32'd127);
               write_register(CSR_THR, $urandom_range(0, 24'hFFFFFF));
            end
            3: begin
               write_register(CSR_K, 32'd0);
               write_register(CSR_THR, 32'd0);
            end
            default: begin
               write_register(CSR_K, $urandom_range(0, 127));
               write_register(CSR_THR, ($urandom_range(0, 3) == 0) ? 32'd0 :
                              $urandom_range(0, 24'hFFFFFF));
            end
         endcase
         if (phase == 0) begin
            // receiver stalls while a full list builds up behind it
            hold_req = 1;
            send_run(80);
         end
         repeat ($urandom_range(4, 8))
            send_run(($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 90)) :
                     int'($urandom_range(1, 12)));
      end

      req_tvalid <= 1'b0;
      while (winners_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
